// ===== hdl/urb_pkg.sv =====
// Shared types and codes for the UART receive/transmit ring buffers.
// Used by urb_ctrl, urb_dp, the top level and the port checker; no dependencies.
package urb_pkg;

  // Ring depths (defaults for the top-level parameters)
  localparam int RX_DEPTH_DEF = 32;
  localparam int TX_DEPTH_DEF = 32;

  // Configuration register indexes
  localparam logic CFG_FRAME_START = 1'b0;
  localparam logic CFG_FRAME_STOP  = 1'b1;

  localparam logic [7:0] FRAME_START_RST = 8'hAA;
  localparam logic [7:0] FRAME_STOP_RST  = 8'h55;

  // Operation codes
  localparam logic [2:0] OP_LINE_BYTE = 3'd0;
  localparam logic [2:0] OP_TX_FREE   = 3'd1;
  localparam logic [2:0] OP_READ      = 3'd2;
  localparam logic [2:0] OP_WRITE     = 3'd3;
  localparam logic [2:0] OP_COMMAND   = 3'd4;

  // Source of a byte appended to the transmit ring
  localparam logic [1:0] APP_DATA  = 2'd0;
  localparam logic [1:0] APP_START = 2'd1;
  localparam logic [1:0] APP_STOP  = 2'd2;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
  } in_payload_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic [7:0] send_data;
    logic       send_valid;
    logic       transmit_finished;
    logic       transmit_empty;
    logic       transmit_overflow;
  } out_payload_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       rx_write;
    logic       rx_read;
    logic       tx_append;
    logic [1:0] app_sel;
    logic       tx_pop;
    logic       set_finished;
    logic       capture;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       rx_empty;
    logic       tx_has_data;
  } status_t;

endpackage

// ===== hdl/uart_rx_tx_ring_buffers.sv =====
// Top level of the UART receive/transmit ring buffers.
// Instantiates urb_ctrl and urb_dp; types and codes from urb_pkg.
//
// Usage:
//   in_*  : one transaction per operation (line byte, transmitter free,
//           read byte, write byte, write command) with its data byte.
//   out_* : one result per transaction: read byte, byte to send, and the
//           finished, empty and overflow flags after the operation.
//   cfg_* : write-only frame start/stop bytes; write only while idle.
// From input accept to out_valid, line byte, write byte and misses pass
// through S_EXEC alone; a read or send that hits its ring adds S_WAIT
// (registered memory read); a command write adds S_CMD1 and S_CMD2, as it
// stores three bytes through the single transmit memory write port. After
// the result is taken the block returns to S_IDLE before the next
// transaction is accepted.
// Transactions are handled one at a time: while a result waits on a stalled
// out_ready, in_ready stays low and all state holds.
// Reset empties both rings (indices and pending count to zero), sets the
// finished flag and loads the frame bytes with 0xAA and 0x55; ring contents
// are not cleared, so no clearing pass is needed.
module uart_rx_tx_ring_buffers #(
  parameter int RX_DEPTH = urb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = urb_pkg::TX_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_addr,
  input  logic [7:0]            cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  urb_pkg::in_payload_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output urb_pkg::out_payload_t out_data
);

  urb_pkg::cmd_t    cmd;
  urb_pkg::status_t st;

  urb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  urb_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/urb_ctrl.sv =====
// Sequencer for the ring buffers: accepts one transaction, steps the datapath.
// Depends on urb_pkg (cmd_t, status_t, operation and append codes).
module urb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  urb_pkg::status_t st,
  output urb_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CMD1 = 3'd2;
  localparam logic [2:0] S_CMD2 = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.app_sel = urb_pkg::APP_DATA;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        unique case (st.op)
          urb_pkg::OP_LINE_BYTE: cmd.rx_write = 1'b1;
          urb_pkg::OP_TX_FREE: begin
            if (st.tx_has_data) begin
              cmd.tx_pop = 1'b1;
              state_nxt  = S_WAIT;
            end else begin
              cmd.set_finished = 1'b1;
            end
          end
          urb_pkg::OP_READ: begin
            if (!st.rx_empty) begin
              cmd.rx_read = 1'b1;
              state_nxt   = S_WAIT;
            end
          end
          urb_pkg::OP_WRITE: cmd.tx_append = 1'b1;
          urb_pkg::OP_COMMAND: begin
            cmd.tx_append = 1'b1;
            cmd.app_sel   = urb_pkg::APP_START;
            state_nxt     = S_CMD1;
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_CMD1: begin
        cmd.tx_append = 1'b1;
        state_nxt     = S_CMD2;
      end
      S_CMD2: begin
        cmd.tx_append = 1'b1;
        cmd.app_sel   = urb_pkg::APP_STOP;
        state_nxt     = S_RESP;
      end
      S_WAIT: begin
        cmd.capture = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== hdl/urb_dp.sv =====
// Datapath: both ring memories, their indices, the pending count, config
// registers and the result register. Depends on urb_pkg.
module urb_dp #(
  parameter int RX_DEPTH = urb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = urb_pkg::TX_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_addr,
  input  logic [7:0]            cfg_wdata,
  input  urb_pkg::in_payload_t  in_data,
  input  urb_pkg::cmd_t         cmd,
  output urb_pkg::status_t      st,
  output urb_pkg::out_payload_t out_data
);

  localparam int RIW = $clog2(RX_DEPTH);
  localparam int TIW = $clog2(TX_DEPTH);
  localparam int TCW = $clog2(TX_DEPTH + 1);

  localparam logic [RIW-1:0] RX_LAST = RIW'(RX_DEPTH - 1);
  localparam logic [TIW-1:0] TX_LAST = TIW'(TX_DEPTH - 1);
  localparam logic [TCW-1:0] TX_FULL = TCW'(TX_DEPTH);

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  logic [7:0]     start_byte_r, stop_byte_r;
  logic [2:0]     op_r;
  logic [7:0]     data_r;
  logic [RIW-1:0] rx_wr_idx_r, rx_rd_idx_r;
  logic [TIW-1:0] tx_fill_idx_r, tx_send_idx_r;
  logic [TCW-1:0] tx_pend_r;
  logic           finished_r;
  logic [7:0]     rx_q_r, tx_q_r;
  logic [7:0]     rd_data_r, sd_data_r;
  logic           rd_valid_r, sd_valid_r, ovf_r;
  logic [7:0]     app_byte;
  logic           tx_full;

  assign tx_full = (tx_pend_r == TX_FULL);

  // Pick the byte to append
  always_comb begin
    case (cmd.app_sel)
      urb_pkg::APP_START: app_byte = start_byte_r;
      urb_pkg::APP_STOP:  app_byte = stop_byte_r;
      default:            app_byte = data_r;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= urb_pkg::FRAME_START_RST;
      stop_byte_r  <= urb_pkg::FRAME_STOP_RST;
    end else if (cfg_wr_en) begin
      if (cfg_addr == urb_pkg::CFG_FRAME_START) start_byte_r <= cfg_wdata;
      else                                      stop_byte_r  <= cfg_wdata;
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= in_data.operation;
      data_r <= in_data.data_byte;
    end
  end

  // Receive ring memory
  always_ff @(posedge clk) begin
    if (cmd.rx_write) rx_mem[rx_wr_idx_r] <= data_r;
    if (cmd.rx_read)  rx_q_r <= rx_mem[rx_rd_idx_r];
  end

  // Transmit ring memory
  always_ff @(posedge clk) begin
    if (cmd.tx_append && !tx_full) tx_mem[tx_fill_idx_r] <= app_byte;
    if (cmd.tx_pop)                tx_q_r <= tx_mem[tx_send_idx_r];
  end

  // Indices, pending count and finished flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wr_idx_r   <= '0;
      rx_rd_idx_r   <= '0;
      tx_fill_idx_r <= '0;
      tx_send_idx_r <= '0;
      tx_pend_r     <= '0;
      finished_r    <= 1'b1;
    end else begin
      if (cmd.rx_write)
        rx_wr_idx_r <= (rx_wr_idx_r == RX_LAST) ? '0 : rx_wr_idx_r + 1'b1;
      if (cmd.rx_read)
        rx_rd_idx_r <= (rx_rd_idx_r == RX_LAST) ? '0 : rx_rd_idx_r + 1'b1;
      if (cmd.tx_append && !tx_full) begin
        tx_fill_idx_r <= (tx_fill_idx_r == TX_LAST) ? '0 : tx_fill_idx_r + 1'b1;
        tx_pend_r     <= tx_pend_r + 1'b1;
      end
      if (cmd.tx_pop) begin
        tx_send_idx_r <= (tx_send_idx_r == TX_LAST) ? '0 : tx_send_idx_r + 1'b1;
        tx_pend_r     <= tx_pend_r - 1'b1;
        finished_r    <= 1'b0;
      end
      if (cmd.set_finished) finished_r <= 1'b1;
    end
  end

  // Result register: clear on load, fill from the ring read or an overflow
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      rd_data_r  <= '0;
      rd_valid_r <= 1'b0;
      sd_data_r  <= '0;
      sd_valid_r <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      if (cmd.capture) begin
        if (op_r == urb_pkg::OP_READ) begin
          rd_data_r  <= rx_q_r;
          rd_valid_r <= 1'b1;
        end else begin
          sd_data_r  <= tx_q_r;
          sd_valid_r <= 1'b1;
        end
      end
      if (cmd.tx_append && tx_full) ovf_r <= 1'b1;
    end
  end

  assign st.op          = op_r;
  assign st.rx_empty    = (rx_rd_idx_r == rx_wr_idx_r);
  assign st.tx_has_data = (tx_pend_r != '0);

  assign out_data.read_data         = rd_data_r;
  assign out_data.read_valid        = rd_valid_r;
  assign out_data.send_data         = sd_data_r;
  assign out_data.send_valid        = sd_valid_r;
  assign out_data.transmit_finished = finished_r;
  assign out_data.transmit_empty    = (tx_pend_r == '0);
  assign out_data.transmit_overflow = ovf_r;

endmodule

// ===== hdl/urb_checker.sv =====
// Port-level checks for the ring buffer top level, attached by bind.
// Depends on urb_pkg payload types.
module urb_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input urb_pkg::out_payload_t out_data,
  input logic                  out_valid,
  input logic                  out_ready
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Drop ready for the cycle after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new transaction accepted while one is in progress");

  // Never accept while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // Zero data unless marked valid
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.read_valid || out_data.read_data == 8'd0) &&
                  (out_data.send_valid || out_data.send_data == 8'd0))
    else $error("data field set without its valid bit");

  // Overflow only with a full, hence non-empty, transmit ring
  a_ovf_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.transmit_overflow |-> !out_data.transmit_empty)
    else $error("overflow reported with empty transmit ring");

endmodule

bind uart_rx_tx_ring_buffers urb_checker u_urb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the UART receive/transmit ring buffers.
// Drives uart_rx_tx_ring_buffers (types and codes from urb_pkg) and checks every
// result against an in-bench prediction of both rings and the frame registers.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RXD = urb_pkg::RX_DEPTH_DEF;
  localparam int TXD = urb_pkg::TX_DEPTH_DEF;
  localparam int QUIET_LIMIT = 1000;

  // Operation codes the block leaves unused
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_addr = urb_pkg::CFG_FRAME_START;
  logic [7:0]            cfg_wdata = 8'h00;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  urb_pkg::in_payload_t  in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  urb_pkg::out_payload_t out_data;

  // Typed expectation travelling with the transaction on the input channel
  logic                  row_want_en = 1'b0;
  urb_pkg::out_payload_t row_want = '0;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Predicted state of the rings and the frame registers
  logic [7:0]             frame_start = urb_pkg::FRAME_START_RST;
  logic [7:0]             frame_stop  = urb_pkg::FRAME_STOP_RST;
  logic [7:0]             rx_store [RXD];
  logic [7:0]             tx_store [TXD];
  logic [$clog2(RXD)-1:0] rx_wr = '0;
  logic [$clog2(RXD)-1:0] rx_rd = '0;
  logic [$clog2(TXD)-1:0] tx_fill = '0;
  logic [$clog2(TXD)-1:0] tx_send = '0;
  logic [$clog2(TXD):0]   tx_count = '0;
  logic                   tx_finished = 1'b1;

  urb_pkg::out_payload_t due_results [$];

  typedef struct {
    urb_pkg::in_payload_t  item;
    int                    reps;
    bit                    typed;
    urb_pkg::out_payload_t want;
  } stim_row_t;

  stim_row_t directed_rows [$];

  uart_rx_tx_ring_buffers #(
    .RX_DEPTH(RXD),
    .TX_DEPTH(TXD)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Append one byte to the predicted transmit ring; return 1 if it was dropped
  function automatic bit tx_push(logic [7:0] b);
    if (tx_count >= TXD) return 1'b1;
    tx_store[tx_fill] = b;
    tx_fill = (tx_fill == TXD - 1) ? '0 : tx_fill + 1'b1;
    tx_count = tx_count + 1'b1;
    return 1'b0;
  endfunction

  // Apply one operation to the predicted rings and return the result it gives
  function automatic urb_pkg::out_payload_t rings_step(urb_pkg::in_payload_t it);
    urb_pkg::out_payload_t r;
    r = '0;
    case (it.operation)
      urb_pkg::OP_LINE_BYTE: begin
        rx_store[rx_wr] = it.data_byte;
        rx_wr = (rx_wr == RXD - 1) ? '0 : rx_wr + 1'b1;
      end
      urb_pkg::OP_TX_FREE: begin
        if (tx_count != 0) begin
          r.send_data = tx_store[tx_send];
          r.send_valid = 1'b1;
          tx_send = (tx_send == TXD - 1) ? '0 : tx_send + 1'b1;
          tx_count = tx_count - 1'b1;
          tx_finished = 1'b0;
        end else begin
          tx_finished = 1'b1;
        end
      end
      urb_pkg::OP_READ: begin
        if (rx_rd != rx_wr) begin
          r.read_data = rx_store[rx_rd];
          r.read_valid = 1'b1;
          rx_rd = (rx_rd == RXD - 1) ? '0 : rx_rd + 1'b1;
        end
      end
      urb_pkg::OP_WRITE: r.transmit_overflow = tx_push(it.data_byte);
      urb_pkg::OP_COMMAND: begin
        // Each of the three bytes looks for room on its own
        if (tx_push(frame_start)) r.transmit_overflow = 1'b1;
        if (tx_push(it.data_byte)) r.transmit_overflow = 1'b1;
        if (tx_push(frame_stop)) r.transmit_overflow = 1'b1;
      end
      default: ;
    endcase
    r.transmit_finished = tx_finished;
    r.transmit_empty = (tx_count == 0);
    return r;
  endfunction

  function automatic urb_pkg::out_payload_t result_of(logic [7:0] rd, logic rv,
                                                      logic [7:0] sd, logic sv,
                                                      logic fin, logic emp, logic ovf);
    return urb_pkg::out_payload_t'{rd, rv, sd, sv, fin, emp, ovf};
  endfunction

  function automatic void add_row(logic [2:0] op, logic [7:0] d, int reps, bit typed,
                                  urb_pkg::out_payload_t want);
    stim_row_t row;
    row.item = urb_pkg::in_payload_t'{op, d};
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  // Track register writes, predict accepted transactions, check results
  always @(posedge clk) begin
    urb_pkg::out_payload_t want;
    if (rst_n) begin
      if (cfg_wr_en) begin
        if (cfg_addr == urb_pkg::CFG_FRAME_START) frame_start <= cfg_wdata;
        else frame_stop <= cfg_wdata;
      end
      if (in_valid && in_ready) begin
        want = rings_step(in_data);
        if (row_want_en) want = row_want;
        due_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result with nothing expected: %0h", out_data);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("read_data", want.read_data, out_data.read_data);
          check_field("read_valid", 8'(want.read_valid), 8'(out_data.read_valid));
          check_field("send_data", want.send_data, out_data.send_data);
          check_field("send_valid", 8'(want.send_valid), 8'(out_data.send_valid));
          check_field("transmit_finished", 8'(want.transmit_finished),
                      8'(out_data.transmit_finished));
          check_field("transmit_empty", 8'(want.transmit_empty),
                      8'(out_data.transmit_empty));
          check_field("transmit_overflow", 8'(want.transmit_overflow),
                      8'(out_data.transmit_overflow));
        end
      end
    end
  end

  // End the run when nothing has been accepted for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Present one transaction after a random gap and hold it until accepted
  task automatic drive_item(urb_pkg::in_payload_t it, bit typed,
                            urb_pkg::out_payload_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    row_want_en <= typed;
    row_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drain the block, let it settle, then load both frame bytes
  task automatic set_frame(logic [7:0] start_b, logic [7:0] stop_b);
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (5) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= urb_pkg::CFG_FRAME_START;
    cfg_wdata <= start_b;
    @(negedge clk);
    cfg_addr <= urb_pkg::CFG_FRAME_STOP;
    cfg_wdata <= stop_b;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [2:0] pick_op(int kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      0: return (r < 80) ? urb_pkg::OP_LINE_BYTE :
                (r < 95) ? urb_pkg::OP_READ : 3'($urandom_range(0, 4));
      1: return (r < 80) ? urb_pkg::OP_READ :
                (r < 90) ? urb_pkg::OP_LINE_BYTE : urb_pkg::OP_TX_FREE;
      2: return (r < 45) ? urb_pkg::OP_WRITE :
                (r < 85) ? urb_pkg::OP_COMMAND : urb_pkg::OP_TX_FREE;
      3: return (r < 80) ? urb_pkg::OP_TX_FREE :
                (r < 90) ? urb_pkg::OP_WRITE : urb_pkg::OP_READ;
      default: begin
        if (r < 90) return 3'($urandom_range(0, 4));
        return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
    endcase
  endfunction

  // Random traffic in bursts: receive floods, read drains, transmit fills and
  // drains, and mixed noise including the unused codes
  task automatic run_random(int n_items);
    int counted;
    int seg_left;
    int seg_kind;
    int pick;
    urb_pkg::in_payload_t it;
    counted = 0;
    seg_left = 0;
    seg_kind = 0;
    while (counted < n_items) begin
      if (seg_left == 0) begin
        seg_kind = $urandom_range(0, 4);
        seg_left = $urandom_range(1, 48);
      end
      seg_left--;
      it.operation = pick_op(seg_kind);
      pick = $urandom_range(0, 9);
      it.data_byte = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      drive_item(it, 1'b0, '0);
      if (it.operation <= urb_pkg::OP_COMMAND) counted++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset frame bytes
    tx_idle_pct = 13;
    rx_stall_pct = 54;
    add_row(urb_pkg::OP_TX_FREE, 8'h00, 1, 1'b1,
            result_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    add_row(urb_pkg::OP_READ, 8'h00, 1, 1'b1,
            result_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    add_row(OP_SPARE_LO, 8'hFF, 1, 1'b1,
            result_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    add_row(OP_SPARE_HI, 8'h00, 1, 1'b1,
            result_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    add_row(urb_pkg::OP_LINE_BYTE, 8'h00, 1, 1'b1,
            result_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    add_row(urb_pkg::OP_LINE_BYTE, 8'hFF, 1, 1'b1,
            result_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    add_row(urb_pkg::OP_READ, 8'h00, 1, 1'b1,
            result_of(8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    add_row(urb_pkg::OP_READ, 8'h00, 1, 1'b1,
            result_of(8'hFF, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    add_row(urb_pkg::OP_WRITE, 8'hFF, 1, 1'b1,
            result_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
    add_row(urb_pkg::OP_TX_FREE, 8'h00, 1, 1'b1,
            result_of(8'h00, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0));
    add_row(urb_pkg::OP_COMMAND, 8'h00, 1, 1'b1,
            result_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    add_row(urb_pkg::OP_TX_FREE, 8'h00, 3, 1'b0, '0);
    add_row(urb_pkg::OP_TX_FREE, 8'h00, 1, 1'b1,
            result_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    // Fill the transmit ring to one short of full, then overflow it
    add_row(urb_pkg::OP_COMMAND, 8'hFF, 10, 1'b0, '0);
    add_row(urb_pkg::OP_WRITE, 8'h00, 1, 1'b0, '0);
    add_row(urb_pkg::OP_COMMAND, 8'h3C, 1, 1'b1,
            result_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1));
    add_row(urb_pkg::OP_WRITE, 8'h81, 1, 1'b1,
            result_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1));
    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].reps)
        drive_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases across frame settings and idling patterns
    set_frame(8'h00, 8'hFF);
    run_random(170);

    set_frame(8'hFF, 8'h00);
    tx_idle_pct = 54;
    rx_stall_pct = 13;
    run_random(170);

    set_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    run_random(170);

    // Drain and let the block settle before the verdict
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
